// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== rtl/kccl_pkg.sv =====
// shared types and constants of the key change code lister
package kccl_pkg;

    localparam int KEY_WORDS = 4;
    localparam int WIDX_BITS = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [1:0] KIND_PRESSED  = 2'd0;
    localparam logic [1:0] KIND_RELEASED = 2'd1;
    localparam logic [1:0] KIND_ACTIVE   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_REPORT_KIND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CODES   = 2'd1;

    typedef struct packed {
        logic load;
        logic advance;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic       in_range;
        logic       done;
        logic       bit0;
        logic       out_free;
        logic [8:0] limit;
    } status_t;

endpackage

// ===== rtl/key_change_code_lister_core.sv =====
// top level of the key change code lister
// Takes one 32-key word of a keyboard scan per request and reports the code
// (word_index*32+bit) of each newly pressed, newly released or active key,
// lowest bit first. A word is loaded, then the bit-serial mask shifter walks
// the bit positions up to its highest reported key, emitting a code at each
// reported key while the result channel is free, and the scan closes; a new
// word is taken only after the scan closes. A stalled result channel holds
// the scan. Word 0 restarts the per-scan count; once max_codes codes are out,
// later codes of the scan are dropped. Words whose index lies beyond the
// stored scan are taken and ignored.
`include "assert_macros.svh"

module key_change_code_lister_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // word_index [2:0], key_flags [34:3], zero [39:35]
    input  logic [kccl_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // key code [7:0], codes_so_far [16:8], zero [23:17]
    output logic [kccl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    // limit_hit [0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kccl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kccl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    kccl_pkg::cmd_t    cmd;
    kccl_pkg::status_t status;

    assign cfg_ready = 1'b1;

    kccl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kccl_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    `ASSERT_IMPLY(a_count_nonzero, aclk, aresetn, m_tvalid, m_tdata[16:8] != 9'd0)
    `ASSERT_IMPLY(a_hit_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    `ASSERT_IMPLY(a_count_in_limit, aclk, aresetn, m_tvalid, m_tdata[16:8] <= status.limit)
    `ASSERT_NEVER(a_emit_when_busy, aclk, aresetn, cmd.emit && !status.out_free)
    `ASSERT_NEVER(a_load_when_busy, aclk, aresetn, cmd.load && !s_tready)

endmodule

// ===== rtl/kccl_ctrl.sv =====
// controller state machine: request intake and bit scan sequencing
module kccl_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  kccl_pkg::status_t status,
    output kccl_pkg::cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        cmd.emit    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && status.in_range) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.done) begin
                    state_next = ST_IDLE;
                end else if (!status.bit0) begin
                    cmd.advance = 1'b1;
                end else if (status.out_free) begin
                    cmd.advance = 1'b1;
                    cmd.emit    = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/kccl_dpath.sv =====
// datapath: config registers, previous scan words, mask shifter, count and output register
module kccl_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [kccl_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                cfg_valid,
    input  logic [kccl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kccl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  kccl_pkg::cmd_t                      cmd,
    output kccl_pkg::status_t                   status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kccl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    logic [1:0]  report_kind_reg;
    logic [8:0]  max_codes_reg;
    logic [31:0] prev_reg [kccl_pkg::KEY_WORDS];
    logic [31:0] mask_reg;
    logic [2:0]  widx_reg;
    logic [4:0]  bit_reg;
    logic [8:0]  count_reg;
    logic        m_tvalid_reg;
    logic [7:0]  code_reg;
    logic [8:0]  codes_so_far_reg;
    logic        last_reg;
    logic        hit_reg;

    logic [2:0]                     in_widx;
    logic [31:0]                    in_flags;
    logic [kccl_pkg::WIDX_BITS-1:0] prev_addr;
    logic [31:0]                    prev_word;
    logic [31:0]                    changed;
    logic [31:0]                    mask_next;
    logic [8:0]                     limit;
    logic [8:0]                     count_inc;
    logic                           out_free;

    assign in_widx   = s_tdata[2:0];
    assign in_flags  = s_tdata[34:3];
    assign prev_addr = in_widx[kccl_pkg::WIDX_BITS-1:0];
    assign prev_word = prev_reg[prev_addr];
    assign changed   = in_flags ^ prev_word;

    always_comb begin
        case (report_kind_reg)
            kccl_pkg::KIND_PRESSED:  mask_next = changed & in_flags;
            kccl_pkg::KIND_RELEASED: mask_next = changed & prev_word;
            kccl_pkg::KIND_ACTIVE:   mask_next = in_flags;
            default:                 mask_next = 32'd0;
        endcase
    end

    // zero acts as one, anything above 256 as 256
    always_comb begin
        if (max_codes_reg == 9'd0) begin
            limit = 9'd1;
        end else if (max_codes_reg > 9'd256) begin
            limit = 9'd256;
        end else begin
            limit = max_codes_reg;
        end
    end

    assign count_inc = count_reg + 9'd1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign status.in_range = ({1'b0, in_widx} < 4'(kccl_pkg::KEY_WORDS));
    assign status.done     = (mask_reg == 32'd0) || (count_reg >= limit);
    assign status.bit0     = mask_reg[0];
    assign status.out_free = out_free;
    assign status.limit    = limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_kind_reg <= kccl_pkg::KIND_PRESSED;
            max_codes_reg   <= 9'd256;
        end else if (cfg_valid) begin
            if (cfg_index == kccl_pkg::REG_REPORT_KIND) begin
                report_kind_reg <= cfg_data[1:0];
            end else if (cfg_index == kccl_pkg::REG_MAX_CODES) begin
                max_codes_reg <= cfg_data[8:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < kccl_pkg::KEY_WORDS; i++) begin
                prev_reg[i] <= 32'd0;
            end
            count_reg <= 9'd0;
        end else if (cmd.load) begin
            prev_reg[prev_addr] <= in_flags;
            if (in_widx == 3'd0) begin
                count_reg <= 9'd0;
            end
        end else if (cmd.emit) begin
            count_reg <= count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 32'd0;
        end else if (cmd.load) begin
            mask_reg <= mask_next;
        end else if (cmd.advance) begin
            mask_reg <= {1'b0, mask_reg[31:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            widx_reg <= in_widx;
            bit_reg  <= 5'd0;
        end else if (cmd.advance) begin
            bit_reg <= bit_reg + 5'd1;
        end
    end

    // output register, parts the scan from the result channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            code_reg         <= {widx_reg, bit_reg};
            codes_so_far_reg <= count_inc;
            hit_reg          <= (count_inc >= limit);
            last_reg         <= (mask_reg[31:1] == 31'd0) || (count_inc >= limit);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, codes_so_far_reg, code_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = hit_reg;

endmodule
